### hdl/md5_pkg.sv
// ---------------------------------------------------------------------------
// MD5 package
// Shared types and constants for the MD5 digest unit.
// ---------------------------------------------------------------------------
`default_nettype none
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_byte;   // write one byte into the block buffer
    logic [5:0] byte_pos;    // byte position for the write
    logic [7:0] byte_val;    // value to write
    logic       clear_tail;  // zero bytes above byte_pos (padding)
    logic       clear_head;  // zero words 0..13 (second padding block)
    logic       put_length;  // write bit count into words 14 and 15
    logic       round_start; // copy chaining words into round registers
    logic       round_en;    // perform one round
    logic [5:0] round_idx;   // round number
    logic       round_fold;  // add round registers into chaining words
    logic       restart;     // chaining words back to initial values
  } md5_cmd_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case (i[5:4])
      2'd0: r = (i[1:0] == 2'd0) ? 5'd7 : (i[1:0] == 2'd1) ? 5'd12 :
                (i[1:0] == 2'd2) ? 5'd17 : 5'd22;
      2'd1: r = (i[1:0] == 2'd0) ? 5'd5 : (i[1:0] == 2'd1) ? 5'd9 :
                (i[1:0] == 2'd2) ? 5'd14 : 5'd20;
      2'd2: r = (i[1:0] == 2'd0) ? 5'd4 : (i[1:0] == 2'd1) ? 5'd11 :
                (i[1:0] == 2'd2) ? 5'd16 : 5'd23;
      default: r = (i[1:0] == 2'd0) ? 5'd6 : (i[1:0] == 2'd1) ? 5'd10 :
                   (i[1:0] == 2'd2) ? 5'd15 : 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] n;
    n = i[3:0];
    case (i[5:4])
      2'd0: g = n;
      2'd1: g = 4'((n << 2) + n + 4'd1);
      2'd2: g = 4'((n << 1) + n + 4'd5);
      default: g = 4'((n << 3) - n);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

### hdl/md5_datapath.sv
// ---------------------------------------------------------------------------
// MD5 datapath
// Block buffer, round registers, one round unit and chaining words.
// ---------------------------------------------------------------------------
`default_nettype none
module md5_datapath (
  input  wire logic             clk,
  input  wire md5_pkg::md5_cmd_t cmd,
  input  wire logic [63:0]      bit_count,
  output logic [127:0]          chain
);

  logic [31:0] blk [16];
  logic [31:0] ra, rb, rc, rd;
  logic [31:0] ca, cb, cc, cd;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  always_comb begin
    case (cmd.round_idx[5:4])
      2'd0: f = rd ^ (rb & (rc ^ rd));
      2'd1: f = rc ^ (rd & (rb ^ rc));
      2'd2: f = rb ^ rc ^ rd;
      default: f = rc ^ (rb | ~rd);
    endcase
    sum = ra + f + md5_pkg::round_const(cmd.round_idx)
        + blk[md5_pkg::word_index(cmd.round_idx)];
    s   = md5_pkg::rot_amount(cmd.round_idx);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      for (int b = 0; b < 4; b++) begin
        if (cmd.load_byte && cmd.byte_pos == 6'(w * 4 + b)) begin
          blk[w][b*8 +: 8] <= cmd.byte_val;
        end else if (cmd.clear_tail && 6'(w * 4 + b) > cmd.byte_pos) begin
          blk[w][b*8 +: 8] <= 8'h00;
        end
      end
      if (cmd.clear_head && w < 14) begin
        blk[w] <= 32'h0;
      end
    end
    if (cmd.put_length) begin
      blk[14] <= bit_count[31:0];
      blk[15] <= bit_count[63:32];
    end
    if (cmd.round_start) begin
      ra <= ca; rb <= cb; rc <= cc; rd <= cd;
    end else if (cmd.round_en) begin
      ra <= rd; rd <= rc; rc <= rb; rb <= rb + rot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      ca <= md5_pkg::IV_A; cb <= md5_pkg::IV_B;
      cc <= md5_pkg::IV_C; cd <= md5_pkg::IV_D;
    end else if (cmd.round_fold) begin
      ca <= ca + ra; cb <= cb + rb; cc <= cc + rc; cd <= cd + rd;
    end
  end

  assign chain = {cd, cc, cb, ca};

endmodule
`default_nettype wire

### hdl/md5_control.sv
// ---------------------------------------------------------------------------
// MD5 controller
// Accepts requests, counts bits, sequences rounds, padding and the result.
// ---------------------------------------------------------------------------
`default_nettype none
module md5_control (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        no_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             snap,
  output logic [63:0]      bit_count,
  output md5_pkg::md5_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_FOLD  = 7'b0001000,
    S_PAD   = 7'b0010000,
    S_LEN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [5:0] idx;
  logic       pad_mode;  // compression belongs to final padding
  logic       last;      // final block in progress
  logic       fin;       // end pending after the current block
  logic       take;
  logic       out_free;  // result register empty or being emptied
  logic [5:0] pos;

  assign pos      = bit_count[8:3];
  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.round_idx = idx;
    state_next = state;
    snap = 1'b0;
    case (state)
      S_IDLE: begin
        if (take) begin
          cmd.byte_pos = pos;
          cmd.byte_val = data_byte;
          cmd.load_byte = !no_byte;
          if (!no_byte && pos == 6'd63) state_next = S_START;
          else if (end_of_message) state_next = S_PAD;
        end
      end
      S_PAD: begin
        cmd.load_byte  = 1'b1;
        cmd.clear_tail = 1'b1;
        cmd.byte_pos   = pos;
        cmd.byte_val   = md5_pkg::PAD_BYTE;
        state_next = (pos >= md5_pkg::LEN_POS) ? S_START : S_LEN;
      end
      S_LEN: begin
        cmd.put_length = 1'b1;
        cmd.clear_head = pad_mode;
        state_next = S_START;
      end
      S_START: begin
        cmd.round_start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (idx == 6'd63) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.round_fold = 1'b1;
        if (last) state_next = S_OUT;
        else if (pad_mode) state_next = S_LEN;
        else if (fin) state_next = S_PAD;
        else state_next = S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          snap = 1'b1;
          cmd.restart = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      pad_mode <= 1'b0;
      last <= 1'b0;
      fin <= 1'b0;
      bit_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == S_ROUND) idx <= idx + 6'd1;
      else idx <= '0;
      case (state)
        S_IDLE: begin
          if (take) begin
            fin <= end_of_message;
            if (!no_byte) bit_count <= bit_count + 64'd8;
          end
        end
        S_PAD: begin
          pad_mode <= (pos >= md5_pkg::LEN_POS);
          last <= (pos < md5_pkg::LEN_POS);
        end
        S_LEN: begin
          pad_mode <= 1'b0;
          last <= 1'b1;
        end
        S_OUT: begin
          if (out_free) begin
            bit_count <= '0;
            last <= 1'b0;
            fin <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_round_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_START) |=> (state == S_ROUND && idx == 6'd0))
    else $error("rounds did not start at zero");
  a_out_after_fold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT)) else $error("stray result");
`endif

endmodule
`default_nettype wire

### hdl/md5_message_digest_unit.sv
// ---------------------------------------------------------------------------
// MD5 message digest unit
// Hashes a byte stream and returns the 128-bit digest at end of message.
// ---------------------------------------------------------------------------
// Throughput: one byte request a cycle while idle; the 64th byte of a block
// stalls the input for start, 64 rounds in one round unit and fold. End of
// message stalls it for padding and one compression, two if padding needs a
// second block, before the digest request appears; the result register lets
// the input run on while a digest waits; only a second one waits for it.
// Reset (rst, synchronous) clears the controller, the bit count and the
// result flag; the chaining words are loaded while reset is held.
`default_nettype none
module md5_message_digest_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        no_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      digest_low,
  output logic [63:0]      digest_high
);

  md5_pkg::md5_cmd_t cmd, cmd_dp;
  logic [63:0]  bit_count;
  logic [127:0] chain;
  logic         snap;
  logic         init_done;

  // The control unit sequences everything; the datapath just follows.
  md5_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .no_byte,
    .end_of_message, .out_valid, .out_ready, .snap, .bit_count, .cmd
  );

  // The chaining words are loaded while reset is held and once after it.
  always_ff @(posedge clk) begin
    if (rst) init_done <= 1'b0;
    else init_done <= 1'b1;
  end

  always_comb begin
    cmd_dp = cmd;
    if (!init_done) cmd_dp.restart = 1'b1;
  end

  md5_datapath u_dp (.clk, .cmd(cmd_dp), .bit_count, .chain);

  // The result register holds the digest while the request waits.
  always_ff @(posedge clk) begin
    if (snap) begin
      digest_low  <= chain[63:0];
      digest_high <= chain[127:64];
    end
  end

endmodule
`default_nettype wire

### sim/md5_message_digest_unit_tb.sv
// ---------------------------------------------------------------------------
// MD5 digest unit testbench
// Sends byte-wise messages through a valid/ready request channel, hashes them
// in a software MD5 alongside, and compares every digest with the oldest one
// still expected. A directed table of messages comes first, then random
// messages of random length, with end markers, stray no-byte requests and
// bursty traffic on both sides.
// ---------------------------------------------------------------------------
`default_nettype none
module md5_message_digest_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_REQUESTS = 1600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        no_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_low;
  logic [63:0] digest_high;

  always #10 clk = ~clk;

  md5_message_digest_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .no_byte(no_byte), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_low(digest_low), .digest_high(digest_high)
  );

  // A row of the directed table. Where 'typed' is set the digest is a well
  // known one and is taken from the row rather than from the software hash.
  typedef struct {
    logic [7:0]  b;
    logic        nb;
    logic        eom;
    bit          typed;
    logic [63:0] lo;
    logic [63:0] hi;
  } stim_row_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  // Software MD5 state, kept in step with every accepted request.
  logic [31:0] sw_chain [4];
  logic [31:0] sw_block [16];
  logic [63:0] sw_bits;
  logic [31:0] sine_table [64];
  int          shift_table [4][4] = '{'{7, 12, 17, 22}, '{5, 9, 14, 20},
                                      '{4, 11, 16, 23}, '{6, 10, 15, 21}};

  digest_t     pending_digests [$];
  int          failures = 0;
  int          digests_seen = 0;
  int          messages_sent = 0;
  int          bytes_sent = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  function automatic void sw_restart();
    sw_chain[0] = md5_pkg::IV_A;
    sw_chain[1] = md5_pkg::IV_B;
    sw_chain[2] = md5_pkg::IV_C;
    sw_chain[3] = md5_pkg::IV_D;
    sw_bits = '0;
  endfunction

  function automatic void sw_compress();
    logic [31:0] a, b, c, d, f, x;
    int g, ph, s;
    a = sw_chain[0]; b = sw_chain[1]; c = sw_chain[2]; d = sw_chain[3];
    for (int i = 0; i < 64; i++) begin
      ph = i / 16;
      case (ph)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      x = a + f + sine_table[i] + sw_block[g];
      s = shift_table[ph][i % 4];
      a = d; d = c; c = b;
      b = b + ((x << s) | (x >> (32 - s)));
    end
    sw_chain[0] += a; sw_chain[1] += b; sw_chain[2] += c; sw_chain[3] += d;
  endfunction

  function automatic void sw_put(int p, logic [7:0] v);
    sw_block[p / 4][(p % 4) * 8 +: 8] = v;
  endfunction

  // Absorbs one request; returns 1 with the digest when the message ends.
  function automatic bit sw_absorb(input logic [7:0] b, input logic nb,
                                   input logic eom, output digest_t dg);
    int p;
    if (!nb) begin
      p = int'(sw_bits[8:3]);
      sw_put(p, b);
      sw_bits += 64'd8;
      if (p == 63) sw_compress();
    end
    if (!eom) return 1'b0;
    p = int'(sw_bits[8:3]);
    sw_put(p, md5_pkg::PAD_BYTE);
    for (int q = p + 1; q < 64; q++) sw_put(q, 8'h00);
    if (p >= 56) begin
      sw_compress();
      for (int k = 0; k < 14; k++) sw_block[k] = '0;
    end
    sw_block[14] = sw_bits[31:0];
    sw_block[15] = sw_bits[63:32];
    sw_compress();
    dg.lo = {sw_chain[1], sw_chain[0]};
    dg.hi = {sw_chain[3], sw_chain[2]};
    sw_restart();
    return 1'b1;
  endfunction

  // Drives one request and waits for its acceptance. The sender runs in
  // bursts; between bursts valid is dropped for a random gap.
  task automatic send_request(input logic [7:0] b, input logic nb, input logic eom,
                              input bit typed, input digest_t typed_dg);
    digest_t dg;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    no_byte        <= nb;
    end_of_message <= eom;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    if (sw_absorb(b, nb, eom, dg)) begin
      pending_digests.push_back(typed ? typed_dg : dg);
      messages_sent++;
    end
    if (!nb) bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Sends a random message of the given length, with stray no-byte requests
  // mixed in and either the last byte or a separate request ending it.
  task automatic send_message(input int len);
    digest_t none;
    logic [7:0] b;
    bit sep_end;
    none = '{lo: '0, hi: '0};
    sep_end = (len == 0) || $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(8'($urandom), 1'b1, 1'b0, 1'b0, none);
      case ($urandom_range(0, 9))
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_request(b, 1'b0, (i == len - 1) && !sep_end, 1'b0, none);
    end
    if (sep_end) send_request(8'($urandom), 1'b1, 1'b1, 1'b0, none);
  endtask

  // The receiver cycles through three stall habits: always ready, ready at
  // random, and ready only one cycle in four.
  int rx_tick = 0;
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case ((rx_tick / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      default: out_ready <= (rx_tick % 4 == 0);
    endcase
  end

  // Digest checker: every accepted digest is matched against the oldest one
  // still expected, field by field.
  always @(posedge clk) begin
    digest_t want;
    if (!rst && out_valid && out_ready) begin
      digests_seen++;
      if (pending_digests.size() == 0) begin
        $error("digest with none expected: low %h high %h", digest_low, digest_high);
        failures++;
      end else begin
        want = pending_digests.pop_front();
        if (digest_low !== want.lo) begin
          $error("digest_low: expected %h, actual %h", want.lo, digest_low);
          failures++;
        end
        if (digest_high !== want.hi) begin
          $error("digest_high: expected %h, actual %h", want.hi, digest_high);
          failures++;
        end
      end
    end
  end

  // Watchdog: too long without any request accepted on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t dir_rows [12];

  initial begin
    int len, sel;
    digest_t dg;
    int boundary_lens [10];

    boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    for (int i = 0; i < 64; i++)
      sine_table[i] = 32'(longint'($floor((($sin(i + 1.0) < 0.0) ? -$sin(i + 1.0)
                                                                 : $sin(i + 1.0))
                                           * 4294967296.0)));
    sw_restart();
    for (int k = 0; k < 16; k++) sw_block[k] = '0;

    // Empty message, "a", then "abc" with stray no-byte requests inside it
    // and a separate end marker, the byte extremes, and an empty message
    // straight after a digest to show the restart.
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1, 1'b1, 64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9},
      '{8'h61, 1'b0, 1'b1, 1'b1, 64'ha8b6f1c0b975c10c, 64'h61267769e299c331},
      '{8'h5a, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
      '{8'h61, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{8'h62, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{8'ha5, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
      '{8'h63, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{8'hff, 1'b1, 1'b1, 1'b1, 64'hb04fd23c98500190, 64'h727fe1287d3f96d6},
      '{8'hff, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{8'hff, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
      '{8'h00, 1'b1, 1'b1, 1'b1, 64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      dg = '{lo: dir_rows[r].lo, hi: dir_rows[r].hi};
      send_request(dir_rows[r].b, dir_rows[r].nb, dir_rows[r].eom, dir_rows[r].typed, dg);
    end

    // Random messages: mostly short, some on the padding boundaries where a
    // second final block is needed, a few long ones spanning several blocks.
    while (bytes_sent < RANDOM_REQUESTS) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) len = $urandom_range(0, 70);
      else if (sel < 9) len = boundary_lens[$urandom_range(0, 9)];
      else len = $urandom_range(71, 200);
      send_message(len);
      // Once midway, hold the sender back until every digest is home.
      if (messages_sent == 20) begin
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending_digests.size() != 0);
      end
    end
    in_valid <= 1'b0;

    while (pending_digests.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("Covered %0d messages (%0d bytes), %0d digests checked, including empty",
             messages_sent, bytes_sent, digests_seen);
    $display("messages, stray no-byte requests and one- and two-block padding.");
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
